### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the cell id parser RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, disabled while reset is held.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a rising edge.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `ASSERT_AT(lbl, clk, rst_n, !(cond), msg)

`endif

### rtl/rcid_pkg.sv
// ---------------------------------------------------------------------------
// rcid_pkg
// Types and constants shared by the row/column cell id parser modules.
// ---------------------------------------------------------------------------
`default_nettype none

package rcid_pkg;

  // Accumulator width and the width of one step of acc*10+digit
  localparam int unsigned ACC_W  = 31;
  localparam int unsigned WIDE_W = ACC_W + 4;

  // Identifiers shorter than this report bad start
  localparam logic [2:0] MIN_LENGTH = 3'd5;

  localparam logic [7:0] CHAR_R    = 8'h52;
  localparam logic [7:0] CHAR_C    = 8'h43;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_START = 3'd1,
    ST_NO_ROW    = 3'd2,
    ST_ROW_OVF   = 3'd3,
    ST_MISSING_C = 3'd4,
    ST_NO_COL    = 3'd5,
    ST_COL_OVF   = 3'd6,
    ST_TRAILING  = 3'd7
  } rcid_status_t;

  // Parse phase, one-hot
  typedef enum logic [4:0] {
    PH_START = 5'b00001,
    PH_ROW1  = 5'b00010,
    PH_ROW   = 5'b00100,
    PH_COL1  = 5'b01000,
    PH_COL   = 5'b10000
  } rcid_phase_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } rcid_in_t;

  typedef struct packed {
    rcid_status_t     status_code;
    logic [ACC_W-1:0] row_value;
    logic [ACC_W-1:0] column_value;
  } rcid_out_t;

endpackage

`default_nettype wire

### rtl/row_column_cell_id_parser.sv
// ---------------------------------------------------------------------------
// row_column_cell_id_parser
// Parses R<digits>C<digits> cell identifiers one character per transfer.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one ASCII character per transfer, last_char marks the final one.
//   out_* : one result per identifier (status, row, column), given for the
//           transfer that carried last_char; other characters give nothing.
//   Path: the last character passes the input register, then the result
//   register, and out_valid rises when it lands there.
//   Throughput: one character per cycle while in_ready is high. The
//   per-character path is one shift-and-add accumulate step between the
//   input and result registers.
//   Stall: a held result blocks only a following last character; ordinary
//   characters keep flowing into the parse state. in_ready drops only while
//   such a last character waits for the result register.
//   Reset: synchronous active-low rst_n empties both registers and puts the
//   parser at the start of an identifier.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module row_column_cell_id_parser
  import rcid_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire rcid_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output rcid_out_t      out_data
);

  logic      in_valid_r;
  rcid_in_t  in_data_r;
  logic      out_valid_r;
  rcid_out_t out_data_r;
  logic      advance;
  rcid_out_t res;

  // A character moves on unless it is a last one and the result slot is full
  assign advance  = in_valid_r && (!in_data_r.last_char || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  rcid_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (advance),
    .char_i (in_data_r),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_data_r.last_char) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_data_r.last_char) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Assertions
  `ASSERT_AT(a_mid_char_flows, clk, rst_n, in_valid_r && !in_data_r.last_char |-> advance, "non-final character stalled")
  `ASSERT_AT(a_last_lands, clk, rst_n, advance && in_data_r.last_char |=> out_valid_r, "final character gave no result")
  `ASSERT_AT(a_err_zero, clk, rst_n, out_valid_r && out_data_r.status_code != ST_OK |-> out_data_r.row_value == '0 && out_data_r.column_value == '0, "nonzero values with error status")

endmodule

`default_nettype wire

### rtl/rcid_digit_acc.sv
// ---------------------------------------------------------------------------
// rcid_digit_acc
// One decimal accumulate step: acc*10 + digit by shift-and-add, with an
// overflow flag when the result leaves the 31-bit range.
// ---------------------------------------------------------------------------
`default_nettype none

module rcid_digit_acc
  import rcid_pkg::*;
(
  input  wire logic [ACC_W-1:0] acc_i,
  input  wire logic [3:0]       digit_i,
  output logic      [ACC_W-1:0] sum_o,
  output logic                  ovf_o
);

  logic [WIDE_W-1:0] acc_wide;
  logic [WIDE_W-1:0] sum_wide;

  // acc*8 + acc*2 + digit
  assign acc_wide = {4'b0000, acc_i};
  assign sum_wide = (acc_wide << 3) + (acc_wide << 1) + {{(WIDE_W-4){1'b0}}, digit_i};

  assign sum_o = sum_wide[ACC_W-1:0];
  assign ovf_o = |sum_wide[WIDE_W-1:ACC_W];

endmodule

`default_nettype wire

### rtl/rcid_core.sv
// ---------------------------------------------------------------------------
// rcid_core
// Parse state, error latch, length counter and accumulators. Takes one
// character per step and forms the result on the last character.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rcid_core
  import rcid_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      step_i,
  input  wire rcid_in_t  char_i,
  output rcid_out_t      res_o
);

  rcid_phase_t      phase_r, phase_nxt;
  rcid_status_t     err_r, err_nxt;
  logic [ACC_W-1:0] row_r, row_nxt;
  logic [ACC_W-1:0] col_r, col_nxt;
  logic [2:0]       len_r, len_nxt;

  logic             is_digit;
  logic             sel_col;
  logic [ACC_W-1:0] acc_in;
  logic [ACC_W-1:0] acc_sum;
  logic             acc_ovf;
  rcid_status_t     status;

  // Shared accumulate unit: row in row phases, column in column phases
  assign sel_col = (phase_r == PH_COL1) || (phase_r == PH_COL);
  assign acc_in  = sel_col ? col_r : row_r;

  rcid_digit_acc u_acc (
    .acc_i   (acc_in),
    .digit_i (char_i.char_code[3:0]),
    .sum_o   (acc_sum),
    .ovf_o   (acc_ovf)
  );

  // Next state for the current character
  always_comb begin
    is_digit  = char_i.char_code inside {[CHAR_ZERO:CHAR_NINE]};
    phase_nxt = phase_r;
    err_nxt   = err_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    len_nxt   = (len_r < MIN_LENGTH) ? len_r + 3'd1 : len_r;

    if (err_r == ST_OK) begin
      case (phase_r)
        PH_START: begin
          if (char_i.char_code == CHAR_R) phase_nxt = PH_ROW1;
          else                            err_nxt   = ST_BAD_START;
        end
        PH_ROW1: begin
          if (!is_digit)    err_nxt = ST_NO_ROW;
          else if (acc_ovf) err_nxt = ST_ROW_OVF;
          else begin
            row_nxt   = acc_sum;
            phase_nxt = PH_ROW;
          end
        end
        PH_ROW: begin
          if (is_digit) begin
            if (acc_ovf) err_nxt = ST_ROW_OVF;
            else         row_nxt = acc_sum;
          end else if (char_i.char_code == CHAR_C) begin
            phase_nxt = PH_COL1;
          end else begin
            err_nxt = ST_MISSING_C;
          end
        end
        PH_COL1: begin
          if (!is_digit)    err_nxt = ST_NO_COL;
          else if (acc_ovf) err_nxt = ST_COL_OVF;
          else begin
            col_nxt   = acc_sum;
            phase_nxt = PH_COL;
          end
        end
        PH_COL: begin
          if (is_digit) begin
            if (acc_ovf) err_nxt = ST_COL_OVF;
            else         col_nxt = acc_sum;
          end else begin
            err_nxt = ST_TRAILING;
          end
        end
        default: err_nxt = ST_BAD_START;
      endcase
    end
  end

  // Final status from the updated state
  always_comb begin
    if (len_nxt < MIN_LENGTH) begin
      status = ST_BAD_START;
    end else if (err_nxt != ST_OK) begin
      status = err_nxt;
    end else begin
      case (phase_nxt)
        PH_ROW1: status = ST_NO_ROW;
        PH_ROW:  status = ST_MISSING_C;
        PH_COL1: status = ST_NO_COL;
        PH_COL:  status = ST_OK;
        default: status = ST_BAD_START;
      endcase
    end
  end

  assign res_o.status_code  = status;
  assign res_o.row_value    = (status == ST_OK) ? row_nxt : '0;
  assign res_o.column_value = (status == ST_OK) ? col_nxt : '0;

  // State update; the last character returns everything to reset values
  always_ff @(posedge clk) begin
    if (!rst_n || (step_i && char_i.last_char)) begin
      phase_r <= PH_START;
      err_r   <= ST_OK;
      row_r   <= '0;
      col_r   <= '0;
      len_r   <= '0;
    end else if (step_i) begin
      phase_r <= phase_nxt;
      err_r   <= err_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      len_r   <= len_nxt;
    end
  end

  // Assertions
  `ASSERT_AT(a_last_clears, clk, rst_n, step_i && char_i.last_char |=> phase_r == PH_START && err_r == ST_OK && len_r == 3'd0, "state not cleared after last character")
  `ASSERT_AT(a_err_sticky, clk, rst_n, err_r != ST_OK && !(step_i && char_i.last_char) |=> $stable(err_r), "latched error changed")
  `ASSERT_NEVER(a_len_sat, clk, rst_n, len_r > MIN_LENGTH, "length count past saturation")

endmodule

`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the R<digits>C<digits> cell id parser. Characters
// are sent one per transfer; a local parse predictor builds the expected
// status, row and column for each identifier, and every result transfer is
// compared field by field against the oldest prediction. A short directed
// list is followed by random identifiers, mostly well formed, with small
// values and values near the 31-bit limit, plus broken and noise strings,
// under several idle mixes and one long output hold.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rcid_pkg::*;

  localparam int unsigned      DRAIN_TAIL = 8;
  localparam int unsigned      HOLD_LEN   = 300;
  localparam int unsigned      GAP_CAP    = 40;
  localparam longint unsigned  ACC_MAX    = 64'd2147483647;
  localparam logic [WIDE_W-1:0] ACC_LIMIT = WIDE_W'(ACC_MAX);

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  rcid_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  rcid_out_t out_data;

  row_column_cell_id_parser i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state for the identifier in progress
  rcid_phase_t      pr_phase;
  logic [ACC_W-1:0] pr_row;
  logic [ACC_W-1:0] pr_col;
  rcid_status_t     pr_err;
  logic [2:0]       pr_len;

  rcid_out_t  expected_results[$];
  logic [7:0] id_text[$];

  int n_fail = 0;
  int n_chars = 0;
  int n_idents = 0;
  int status_seen[8];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_orders = 0;

  function automatic void clear_parse();
    pr_phase = PH_START;
    pr_row   = '0;
    pr_col   = '0;
    pr_err   = ST_OK;
    pr_len   = '0;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic [WIDE_W-1:0] times_ten_plus(input logic [ACC_W-1:0] acc,
                                                       input logic [7:0] c);
    return WIDE_W'(acc) * WIDE_W'(10) + WIDE_W'(c - CHAR_ZERO);
  endfunction

  // Advance the parse by one character; returns 1 when a result is due
  function automatic logic parse_char(input rcid_in_t item, output rcid_out_t res);
    logic [7:0]        c;
    logic [WIDE_W-1:0] wide;
    rcid_status_t      st;
    c   = item.char_code;
    res = '0;
    if (pr_len < MIN_LENGTH) pr_len = pr_len + 3'd1;
    if (pr_err == ST_OK) begin
      case (pr_phase)
        PH_START: begin
          if (c == CHAR_R) pr_phase = PH_ROW1;
          else pr_err = ST_BAD_START;
        end
        PH_ROW1: begin
          wide = times_ten_plus(pr_row, c);
          if (!is_digit(c)) pr_err = ST_NO_ROW;
          else if (wide > ACC_LIMIT) pr_err = ST_ROW_OVF;
          else begin
            pr_row   = wide[ACC_W-1:0];
            pr_phase = PH_ROW;
          end
        end
        PH_ROW: begin
          wide = times_ten_plus(pr_row, c);
          if (is_digit(c)) begin
            if (wide > ACC_LIMIT) pr_err = ST_ROW_OVF;
            else pr_row = wide[ACC_W-1:0];
          end else if (c == CHAR_C) begin
            pr_phase = PH_COL1;
          end else begin
            pr_err = ST_MISSING_C;
          end
        end
        PH_COL1: begin
          wide = times_ten_plus(pr_col, c);
          if (!is_digit(c)) pr_err = ST_NO_COL;
          else if (wide > ACC_LIMIT) pr_err = ST_COL_OVF;
          else begin
            pr_col   = wide[ACC_W-1:0];
            pr_phase = PH_COL;
          end
        end
        PH_COL: begin
          wide = times_ten_plus(pr_col, c);
          if (!is_digit(c)) pr_err = ST_TRAILING;
          else if (wide > ACC_LIMIT) pr_err = ST_COL_OVF;
          else pr_col = wide[ACC_W-1:0];
        end
        default: pr_err = ST_BAD_START;
      endcase
    end
    if (!item.last_char) return 1'b0;

    // Short strings win over any latched error
    if (pr_len < MIN_LENGTH) st = ST_BAD_START;
    else if (pr_err != ST_OK) st = pr_err;
    else begin
      case (pr_phase)
        PH_ROW1: st = ST_NO_ROW;
        PH_ROW:  st = ST_MISSING_C;
        PH_COL1: st = ST_NO_COL;
        PH_COL:  st = ST_OK;
        default: st = ST_BAD_START;
      endcase
    end
    res.status_code = st;
    if (st == ST_OK) begin
      res.row_value    = pr_row;
      res.column_value = pr_col;
    end
    clear_parse();
    return 1'b1;
  endfunction

  // One character transfer, then a random idle gap on the input
  task automatic send_char(input logic [7:0] c, input logic last);
    rcid_in_t  item;
    rcid_out_t res;
    int        gap;
    item     = '{char_code: c, last_char: last};
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    n_chars++;
    if (parse_char(item, res)) begin
      expected_results.insert(expected_results.size(), res);
      status_seen[res.status_code]++;
      n_idents++;
    end
    gap = 0;
    while (gap < GAP_CAP && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_ident();
    for (int i = 0; i < id_text.size(); i++) send_char(id_text[i], i == id_text.size() - 1);
    id_text.delete();
  endtask

  // Adds one character at the end of the identifier being built
  function automatic void append_char(input logic [7:0] c);
    id_text.insert(id_text.size(), c);
  endfunction

  // Appends optional leading zeros and the decimal digits of v
  task automatic push_number(input longint unsigned v, input int zeros);
    logic [7:0]      digs[$];
    longint unsigned x;
    x = v;
    repeat (zeros) append_char(CHAR_ZERO);
    do begin
      digs.push_front(CHAR_ZERO + 8'(x % 10));
      x = x / 10;
    end while (x != 0);
    foreach (digs[i]) append_char(digs[i]);
  endtask

  function automatic longint unsigned pick_value();
    int mode;
    mode = $urandom_range(0, 99);
    if (mode < 40) return longint'($urandom_range(0, 999));
    if (mode < 60) return longint'($urandom & 32'h7FFF_FFFF);
    if (mode < 75) return ACC_MAX - $urandom_range(0, 20);
    if (mode < 90) return ACC_MAX + 1 + $urandom_range(0, 20);
    return {$urandom, $urandom} % 64'd10000000000;
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 3))
      0:       return CHAR_R;
      1:       return CHAR_C;
      2:       return CHAR_ZERO + 8'($urandom_range(0, 9));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_well_formed();
    append_char(CHAR_R);
    push_number(pick_value(), ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
    append_char(CHAR_C);
    push_number(pick_value(), ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
  endtask

  // Mostly well formed, some damaged, some pure noise
  task automatic build_random_ident();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 65) begin
      push_well_formed();
    end else if (kind < 85) begin
      push_well_formed();
      case ($urandom_range(0, 2))
        0: id_text[$urandom_range(0, id_text.size() - 1)] = noise_char();
        1: begin
          n = $urandom_range(1, id_text.size() - 1);
          id_text = id_text[0:n-1];
        end
        default: repeat ($urandom_range(1, 3)) append_char(noise_char());
      endcase
    end else begin
      repeat ($urandom_range(1, 8)) append_char(noise_char());
    end
  endtask

  // Hold the input idle until every predicted result has been seen
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct     = 0;
    // short identifier with no column digits
    append_char(CHAR_R);
    push_number(12, 0);
    append_char(CHAR_C);
    send_ident();
    // row overflow
    append_char(CHAR_R);
    push_number(64'd9999999999, 0);
    send_ident();
    // early end inside row digits
    append_char(CHAR_R);
    push_number(1234, 0);
    send_ident();
    // single zero byte, last at once
    append_char(8'h00);
    send_ident();
    // early end waiting for a column digit
    append_char(CHAR_R);
    push_number(123, 0);
    append_char(CHAR_C);
    send_ident();
    // trailing 0xFF after the column
    append_char(CHAR_R);
    push_number(1, 0);
    append_char(CHAR_C);
    push_number(1, 0);
    append_char(8'hFF);
    send_ident();
    wait_for_results();
  endtask

  task automatic test_random_mix(input int n, input int idle, input int stall);
    int start;
    send_idle_pct = idle;
    stall_pct     = stall;
    start         = n_chars;
    while (n_chars - start < n) begin
      build_random_ident();
      send_ident();
    end
    wait_for_results();
  endtask

  // Output held off for a long stretch while characters keep coming
  task automatic test_output_hold();
    int start;
    send_idle_pct = 0;
    stall_pct     = 0;
    start         = n_chars;
    hold_orders++;
    while (n_chars - start < 150) begin
      push_well_formed();
      send_ident();
    end
    wait_for_results();
  endtask

  // Receiver: long hold on request, else random stalls
  int hold_taken = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_taken < hold_orders) begin
      hold_taken <= hold_orders;
      hold_left  <= HOLD_LEN;
      out_ready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic check_field(input string what, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      n_fail++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  // Compare each result transfer against the oldest prediction
  always @(posedge clk) begin : result_check
    rcid_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        n_fail++;
        $display("%0t: result with none expected, expected nothing actual %0d/%0d/%0d",
                 $time, out_data.status_code, out_data.row_value, out_data.column_value);
      end else begin
        want = expected_results.pop_front();
        check_field("status", want.status_code, out_data.status_code);
        check_field("row", want.row_value, out_data.row_value);
        check_field("column", want.column_value, out_data.column_value);
      end
    end
  end

  initial begin
    clear_parse();
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_mix(450, 0, 0);
    test_random_mix(450, 57, 0);
    test_random_mix(450, 0, 57);
    test_random_mix(450, 16, 16);
    test_output_hold();

    $display("covered %0d characters in %0d identifiers across four idle mixes and a held output",
             n_chars, n_idents);
    $display("statuses seen, codes 0 to 7: %0d %0d %0d %0d %0d %0d %0d %0d",
             status_seen[ST_OK], status_seen[ST_BAD_START], status_seen[ST_NO_ROW],
             status_seen[ST_ROW_OVF], status_seen[ST_MISSING_C], status_seen[ST_NO_COL],
             status_seen[ST_COL_OVF], status_seen[ST_TRAILING]);
    if (n_fail == 0) begin
      $display("** row_column_cell_id_parser: PASSED **");
    end else begin
      $display("** row_column_cell_id_parser: FAILED **");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("** row_column_cell_id_parser: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
+incdir+rtl
rtl/rcid_pkg.sv
rtl/rcid_digit_acc.sv
rtl/rcid_core.sv
rtl/row_column_cell_id_parser.sv
bench/tb_top.sv
